FILE: rtl/md5bc_pkg.sv
// shared constants, step tables and front-to-back types for the md5 block compressor
`default_nettype none
package md5bc_pkg;

  // md5 chaining initial values
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;

  // block slots in the buffer between front and back
  localparam int unsigned NUM_SLOTS  = 2;
  localparam int unsigned SLOT_BITS  = $clog2(NUM_SLOTS);
  localparam int unsigned WORD_BITS  = 4;
  localparam int unsigned ADDR_BITS  = SLOT_BITS + WORD_BITS;
  localparam logic [WORD_BITS-1:0] LAST_WORD = 4'd15;
  localparam logic [5:0]           LAST_STEP = 6'd63;

  // round codes taken from step[5:4]
  localparam logic [1:0] RND_F = 2'd0;
  localparam logic [1:0] RND_G = 2'd1;
  localparam logic [1:0] RND_H = 2'd2;
  localparam logic [1:0] RND_I = 2'd3;

  // buffer write from front to back
  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr;
    logic [31:0]          data;
  } wr_t;

  // head of the block queue as seen by the back end
  typedef struct packed {
    logic                 valid;
    logic [SLOT_BITS-1:0] slot;
    logic                 restart;
  } blk_t;

  // message word index used by a step
  function automatic logic [3:0] msg_index(input logic [5:0] step);
    logic [3:0] k;
    logic [3:0] idx;
    k = step[3:0];
    unique case (step[5:4])
      RND_F:   idx = k;
      RND_G:   idx = (k << 2) + k + 4'd1;
      RND_H:   idx = (k << 1) + k + 4'd5;
      RND_I:   idx = (k << 3) - k;
      default: idx = k;
    endcase
    return idx;
  endfunction

  // left rotate amount of a step
  function automatic logic [4:0] rot_amt(input logic [5:0] step);
    logic [4:0] r;
    unique case ({step[5:4], step[1:0]})
      4'h0: r = 5'd7;   4'h1: r = 5'd12;  4'h2: r = 5'd17;  4'h3: r = 5'd22;
      4'h4: r = 5'd5;   4'h5: r = 5'd9;   4'h6: r = 5'd14;  4'h7: r = 5'd20;
      4'h8: r = 5'd4;   4'h9: r = 5'd11;  4'hA: r = 5'd16;  4'hB: r = 5'd23;
      4'hC: r = 5'd6;   4'hD: r = 5'd10;  4'hE: r = 5'd15;  4'hF: r = 5'd21;
      default: r = 5'd7;
    endcase
    return r;
  endfunction

  // additive constant of a step
  function automatic logic [31:0] step_const(input logic [5:0] step);
    logic [31:0] c;
    unique case (step)
      6'd0:  c = 32'hD76AA478; 6'd1:  c = 32'hE8C7B756;
      6'd2:  c = 32'h242070DB; 6'd3:  c = 32'hC1BDCEEE;
      6'd4:  c = 32'hF57C0FAF; 6'd5:  c = 32'h4787C62A;
      6'd6:  c = 32'hA8304613; 6'd7:  c = 32'hFD469501;
      6'd8:  c = 32'h698098D8; 6'd9:  c = 32'h8B44F7AF;
      6'd10: c = 32'hFFFF5BB1; 6'd11: c = 32'h895CD7BE;
      6'd12: c = 32'h6B901122; 6'd13: c = 32'hFD987193;
      6'd14: c = 32'hA679438E; 6'd15: c = 32'h49B40821;
      6'd16: c = 32'hF61E2562; 6'd17: c = 32'hC040B340;
      6'd18: c = 32'h265E5A51; 6'd19: c = 32'hE9B6C7AA;
      6'd20: c = 32'hD62F105D; 6'd21: c = 32'h02441453;
      6'd22: c = 32'hD8A1E681; 6'd23: c = 32'hE7D3FBC8;
      6'd24: c = 32'h21E1CDE6; 6'd25: c = 32'hC33707D6;
      6'd26: c = 32'hF4D50D87; 6'd27: c = 32'h455A14ED;
      6'd28: c = 32'hA9E3E905; 6'd29: c = 32'hFCEFA3F8;
      6'd30: c = 32'h676F02D9; 6'd31: c = 32'h8D2A4C8A;
      6'd32: c = 32'hFFFA3942; 6'd33: c = 32'h8771F681;
      6'd34: c = 32'h6D9D6122; 6'd35: c = 32'hFDE5380C;
      6'd36: c = 32'hA4BEEA44; 6'd37: c = 32'h4BDECFA9;
      6'd38: c = 32'hF6BB4B60; 6'd39: c = 32'hBEBFBC70;
      6'd40: c = 32'h289B7EC6; 6'd41: c = 32'hEAA127FA;
      6'd42: c = 32'hD4EF3085; 6'd43: c = 32'h04881D05;
      6'd44: c = 32'hD9D4D039; 6'd45: c = 32'hE6DB99E5;
      6'd46: c = 32'h1FA27CF8; 6'd47: c = 32'hC4AC5665;
      6'd48: c = 32'hF4292244; 6'd49: c = 32'h432AFF97;
      6'd50: c = 32'hAB9423A7; 6'd51: c = 32'hFC93A039;
      6'd52: c = 32'h655B59C3; 6'd53: c = 32'h8F0CCC92;
      6'd54: c = 32'hFFEFF47D; 6'd55: c = 32'h85845DD1;
      6'd56: c = 32'h6FA87E4F; 6'd57: c = 32'hFE2CE6E0;
      6'd58: c = 32'hA3014314; 6'd59: c = 32'h4E0811A1;
      6'd60: c = 32'hF7537E82; 6'd61: c = 32'hBD3AF235;
      6'd62: c = 32'h2AD7D2BB; 6'd63: c = 32'hEB86D391;
      default: c = 32'h0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/md5bc_front.sv
// input side: word position tracking, restart handling and the block slot queue
`default_nettype none
module md5bc_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [31:0]         in_word,
  input  wire                 in_restart,
  output md5bc_pkg::wr_t      wr,
  output md5bc_pkg::blk_t     blk,
  input  wire                 pop
);
  import md5bc_pkg::*;

  logic [SLOT_BITS-1:0] wr_ptr;
  logic [SLOT_BITS-1:0] rd_ptr;
  logic [SLOT_BITS:0]   count;
  logic [SLOT_BITS:0]   count_next;
  logic [WORD_BITS-1:0] pos;
  logic                 pend_restart;
  logic                 slot_restart [NUM_SLOTS];
  logic                 accept;
  logic [WORD_BITS-1:0] eff_pos;
  logic                 last;
  logic                 push;
  logic                 blk_restart;

  // word classification
  assign in_ready    = (count != (SLOT_BITS+1)'(NUM_SLOTS));
  assign accept      = in_valid && in_ready;
  assign eff_pos     = in_restart ? '0 : pos;
  assign last        = (eff_pos == LAST_WORD);
  assign push        = accept && last;
  assign blk_restart = in_restart || pend_restart;

  // buffer write
  assign wr.en   = accept;
  assign wr.addr = {wr_ptr, eff_pos};
  assign wr.data = in_word;

  // queue head
  assign blk.valid   = (count != '0);
  assign blk.slot    = rd_ptr;
  assign blk.restart = slot_restart[rd_ptr];

  // occupancy
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      count        <= '0;
      pos          <= '0;
      pend_restart <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        pos          <= last ? '0 : eff_pos + 1'b1;
        pend_restart <= last ? 1'b0 : blk_restart;
      end
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  // per slot restart mark
  always_ff @(posedge clk) begin
    if (push) begin
      slot_restart[wr_ptr] <= blk_restart;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/md5bc_core.sv
// back end: block buffer memory, 64-step md5 round unit and chaining update
`default_nettype none
module md5bc_core (
  input  wire                 clk,
  input  wire                 rst,
  input  md5bc_pkg::wr_t      wr,
  input  md5bc_pkg::blk_t     blk,
  output logic                pop,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [63:0]         out_low,
  output logic [63:0]         out_high
);
  import md5bc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [31:0]          mem [NUM_SLOTS * 16];
  logic [31:0]          rdata;
  logic [ADDR_BITS-1:0] raddr;
  logic [1:0]           state;
  logic [SLOT_BITS-1:0] slot;
  logic [5:0]           step;
  logic [5:0]           rd_step;
  logic [31:0]          ca, cb, cc, cd;
  logic [31:0]          wa, wb, wc, wd;
  logic [31:0]          f;
  logic [31:0]          t;
  logic [63:0]          dbl;
  logic [31:0]          new_b;
  logic [31:0]          sa, sb, sc, sd;
  logic                 load_out;

  // buffer memory
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

  // read address runs one step ahead of the round unit
  assign rd_step = (state == S_IDLE) ? 6'd0 : step + 6'd1;
  assign raddr   = {(state == S_IDLE) ? blk.slot : slot, msg_index(rd_step)};

  // round function
  always_comb begin
    unique case (step[5:4])
      RND_F:   f = wd ^ (wb & (wc ^ wd));
      RND_G:   f = wc ^ (wd & (wb ^ wc));
      RND_H:   f = wb ^ wc ^ wd;
      RND_I:   f = wc ^ (wb | ~wd);
      default: f = wb;
    endcase
  end

  // one md5 step
  assign t     = wa + f + rdata + step_const(step);
  assign dbl   = {t, t} << rot_amt(step);
  assign new_b = dbl[63:32] + wb;

  // final chaining sums
  assign sa = ca + wa;
  assign sb = cb + wb;
  assign sc = cc + wc;
  assign sd = cd + wd;

  assign pop      = (state == S_RUN) && (step == LAST_STEP);
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  // sequencer and chaining state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      ca        <= IV_A;
      cb        <= IV_B;
      cc        <= IV_C;
      cd        <= IV_D;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (blk.valid) begin
            step  <= '0;
            state <= S_RUN;
            if (blk.restart) begin
              ca <= IV_A;
              cb <= IV_B;
              cc <= IV_C;
              cd <= IV_D;
            end
          end
        end
        S_RUN: begin
          step <= step + 6'd1;
          if (step == LAST_STEP) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            ca    <= sa;
            cb    <= sb;
            cc    <= sc;
            cd    <= sd;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // working words and result payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && blk.valid) begin
      slot <= blk.slot;
      wa   <= blk.restart ? IV_A : ca;
      wb   <= blk.restart ? IV_B : cb;
      wc   <= blk.restart ? IV_C : cc;
      wd   <= blk.restart ? IV_D : cd;
    end else if (state == S_RUN) begin
      wa <= wd;
      wd <= wc;
      wc <= wb;
      wb <= new_b;
    end
    if (load_out) begin
      out_low  <= {sb, sa};
      out_high <= {sd, sc};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/md5_block_compress.sv
// top level of the md5 block compressor: word intake front and compression back
//
//   channel   dir   width            content
//   s_*       in    tdata 32, tuser 1  one message word, restart flag
//   m_*       out   tdata 128        updated chaining value after each block
//
// the front takes one beat per cycle while a block slot is free (two slots)
// the back spends a setup state, the md5 steps and an output state on a block,
// so in a steady stream the back, not the front, sets the pace per block
// the step unit (one md5 step per cycle) sets the sustained throughput
// rst is synchronous and restores the md5 initial chaining value
// a stalled m_tready holds the result; the front keeps filling the free slot
`default_nettype none
module md5_block_compress (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [31:0]  s_tdata,   // [31:0] msg_word
  input  wire          s_tuser,   // [0] restart
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [127:0] m_tdata    // [63:0] digest_low, [127:64] digest_high
);
  import md5bc_pkg::*;

  wr_t         wr;
  blk_t        blk;
  logic        pop;
  logic [63:0] out_low;
  logic [63:0] out_high;

  // word intake and block queue
  md5bc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_word    (s_tdata),
    .in_restart (s_tuser),
    .wr         (wr),
    .blk        (blk),
    .pop        (pop)
  );

  // compression back end
  md5bc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .blk       (blk),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_low   (out_low),
    .out_high  (out_high)
  );

  assign m_tdata = {out_high, out_low};

endmodule
`default_nettype wire
